// File: design/fvn_pkg.sv
package fvn_pkg;

  // field and datapath widths
  localparam int POS_W    = 24;
  localparam int SHIFT_W  = 14;
  localparam int BAND_W   = 3;
  localparam int P_W      = 25;   // shifted coordinate
  localparam int PP_W     = 49;   // coordinate times base scale
  localparam int SX_W     = 57;   // scaled coordinate after octave shift
  localparam int MA_W     = 25;   // multiplier operand A
  localparam int MW_W     = 17;   // multiplier weight operand
  localparam int PROD_W   = MA_W + MW_W;
  localparam int ACC_W    = 64;
  localparam int R1_W     = 24;   // byte lerped along x
  localparam int R2_W     = 40;   // then along y
  localparam int R2_LO_W  = 25;
  localparam int SUM_W    = 60;
  localparam int T_W      = 28;
  localparam int DIFF_W   = 32;
  localparam int DEN_W    = 14;
  localparam int NOISE_W  = 16;
  localparam int TBL_AW   = 16;
  localparam int TBL_DW   = 8;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int DEF_TABLE_SIDE = 256;

  // 0.002 as a 0.32 fraction, split for the 17-bit weight port
  localparam logic [MW_W-1:0] SCALE_LO = 17'd4719;
  localparam logic [MW_W-1:0] SCALE_HI = 17'd131;
  localparam logic [MW_W-1:0] ONE_FRAC = 17'd65536;

  localparam logic [DIFF_W-1:0] BIAS_UNIT = 32'd66584576;
  localparam logic [DEN_W-1:0]  DEN_UNIT  = 14'd1270;

  localparam logic [SHIFT_W-1:0] SHIFT_X_RST = 14'd397;
  localparam logic [SHIFT_W-1:0] SHIFT_Y_RST = 14'd499;
  localparam logic [SHIFT_W-1:0] SHIFT_Z_RST = 14'd541;

  localparam logic [1:0] REG_SHIFT_X = 2'd0;
  localparam logic [1:0] REG_SHIFT_Y = 2'd1;
  localparam logic [1:0] REG_SHIFT_Z = 2'd2;

  localparam logic [4:0] STEP_COORD_LAST = 5'd5;
  localparam logic [4:0] STEP_OCT_FIRST  = 5'd6;
  localparam logic [4:0] STEP_OCT_LAST   = 5'd23;
  localparam logic [3:0] K_END           = 4'd9;
  localparam logic [3:0] RD_LAST         = 4'd8;
  localparam logic [3:0] DIV_LAST        = 4'd15;

  typedef enum logic [1:0] {OP_WRITE, OP_POINT, OP_FRACTAL} op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_POINT, S_COORD, S_SEEK, S_READ, S_MATH,
    S_FINAL, S_CLAMP, S_DIV, S_DONE
  } state_e;

  typedef enum logic [2:0] {A_PX, A_PY, A_PZ, A_BYTE, A_R1, A_R2LO, A_R2HI} a_sel_e;
  typedef enum logic [2:0] {W_CLO, W_CHI, W_FX0, W_FX1, W_FY0, W_FY1, W_FZ0, W_FZ1} w_sel_e;
  typedef enum logic [2:0] {D_ACC, D_PX, D_PY, D_PZ, D_R1, D_R2, D_SUM} dst_e;
  typedef enum logic [1:0] {SH_0, SH_16, SH_25} sh_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [BAND_W-1:0]  freq_bands;
    logic [TBL_AW-1:0]  table_index;
    logic [TBL_DW-1:0]  table_byte;
  } in_word_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise_value;
    logic [TBL_DW-1:0]  sample_byte;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [TBL_DW-1:0] wdata;
  } tbl_req_t;

  typedef struct packed {
    logic       valid;
    a_sel_e     asel;
    logic [2:0] idx;
    w_sel_e     wsel;
    dst_e       dst;
    logic [1:0] didx;
    sh_e        sh;
  } uop_t;

  // microprogram: coordinate scaling, then one octave of lerps
  function automatic uop_t uop_of(input logic [4:0] step);
    uop_t u;
    logic [4:0] i;
    u = '0;
    i = 5'd0;
    case (step)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: begin
        u.valid = 1'b1;
        u.asel  = (step < 5'd2) ? A_PX : (step < 5'd4) ? A_PY : A_PZ;
        u.wsel  = step[0] ? W_CHI : W_CLO;
        u.dst   = !step[0] ? D_ACC : (step < 5'd2) ? D_PX : (step < 5'd4) ? D_PY : D_PZ;
        u.sh    = step[0] ? SH_16 : SH_0;
      end
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13: begin
        i = step - 5'd6;
        u.valid = 1'b1;
        u.asel  = A_BYTE;
        u.idx   = i[2:0];
        u.wsel  = i[0] ? W_FX1 : W_FX0;
        u.dst   = i[0] ? D_R1 : D_ACC;
        u.didx  = i[2:1];
        u.sh    = SH_0;
      end
      5'd15, 5'd16, 5'd17, 5'd18: begin
        i = step - 5'd15;
        u.valid = 1'b1;
        u.asel  = A_R1;
        u.idx   = {1'b0, i[1:0]};
        u.wsel  = i[0] ? W_FY1 : W_FY0;
        u.dst   = i[0] ? D_R2 : D_ACC;
        u.didx  = {1'b0, i[1]};
        u.sh    = SH_0;
      end
      5'd20, 5'd21, 5'd22, 5'd23: begin
        i = step - 5'd20;
        u.valid = 1'b1;
        u.asel  = i[0] ? A_R2HI : A_R2LO;
        u.idx   = {2'b00, i[1]};
        u.wsel  = i[1] ? W_FZ1 : W_FZ0;
        u.dst   = D_SUM;
        u.sh    = i[0] ? SH_25 : SH_0;
      end
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// File: design/fractal_value_noise_3d_sampler.sv
// Fractal value-noise sampler over a square byte table held in one single-port
// 64K x 8 RAM. Words arrive on a valid/stall channel; op 0 writes a table byte
// (no result), op 1 returns the skewed table byte at the shifted point, op 2
// sums three octaves per selected band of trilinear value noise and returns a
// contrast-boosted 16-bit fraction. For a fractal word each enabled octave
// needs eight reads on the one table port and sixteen products on the one
// shared 25x17 multiplier, and the final average is a 16-step restoring
// division unless the result saturates. The block takes no new word while
// one is in work; a finished result waits in the output register so the next
// word is accepted while it is still stalled. TABLE_SIDE must be a power of
// two. Reading a table entry that was never written gives an undefined byte.
module fractal_value_noise_3d_sampler #(
  parameter int TABLE_SIDE = fvn_pkg::DEF_TABLE_SIDE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fvn_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fvn_pkg::out_word_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [fvn_pkg::SHIFT_W-1:0] cfg_data_i
);
  import fvn_pkg::*;

  localparam int SIDE_W = $clog2(TABLE_SIDE);

  // cell of a lattice point: x + 13z, y + 17z, wrapped to the side
  function automatic logic [TBL_AW-1:0] cell_addr(input logic [SIDE_W-1:0] x,
                                                   input logic [SIDE_W-1:0] y,
                                                   input logic [SIDE_W-1:0] z);
    logic [SIDE_W+4:0] tx;
    logic [SIDE_W+4:0] ty;
    logic [31:0]       lin;
    tx  = (SIDE_W+5)'(x) + ((SIDE_W+5)'(z) << 3) + ((SIDE_W+5)'(z) << 2) + (SIDE_W+5)'(z);
    ty  = (SIDE_W+5)'(y) + ((SIDE_W+5)'(z) << 4) + (SIDE_W+5)'(z);
    lin = 32'({ty[SIDE_W-1:0], tx[SIDE_W-1:0]});
    return lin[TBL_AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [SHIFT_W-1:0] shx_q, shy_q, shz_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic [4:0] step_q;
  logic [3:0] k_q;
  logic [3:0] rd_cnt_q;
  logic [3:0] div_cnt_q;
  uop_t       uop_q, issue;

  logic [P_W-1:0]    pt_x_q, pt_y_q, pt_z_q;
  logic [PP_W-1:0]   pp_x_q, pp_y_q, pp_z_q;
  logic [BAND_W-1:0] bands_q;
  logic [3:0]        n_q;
  logic [TBL_DW-1:0] bt_q [8];
  logic [R1_W-1:0]   r1_q [4];
  logic [R2_W-1:0]   r2_q [2];
  logic [ACC_W-1:0]  acc_q;
  logic [SUM_W-1:0]  sum_q;
  logic [DIFF_W-1:0] diff_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [15:0]       dsr_q;
  logic [15:0]       quo_q;
  logic [NOISE_W-1:0] res_noise_q;
  logic [TBL_DW-1:0]  res_byte_q;

  logic in_acc, out_free;
  tbl_req_t          tbl_req;
  logic [TBL_DW-1:0] tbl_rdata;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // shifted coordinates of the incoming word
  logic [P_W-1:0] in_px, in_py, in_pz;
  assign in_px = P_W'(in_data_i.pos_x) + P_W'(shx_q);
  assign in_py = P_W'(in_data_i.pos_y) + P_W'(shy_q);
  assign in_pz = P_W'(in_data_i.pos_z) + P_W'(shz_q);

  // octave k scaling is the base product shifted left by k
  logic [SX_W-1:0]   sx_x, sx_y, sx_z;
  logic [SIDE_W-1:0] ix, iy, iz, cxs, cys, czs;
  logic [15:0]       fx, fy, fz;
  assign sx_x = SX_W'(pp_x_q) << k_q;
  assign sx_y = SX_W'(pp_y_q) << k_q;
  assign sx_z = SX_W'(pp_z_q) << k_q;
  assign ix = sx_x[32 +: SIDE_W];
  assign iy = sx_y[32 +: SIDE_W];
  assign iz = sx_z[32 +: SIDE_W];
  assign fx = sx_x[31:16];
  assign fy = sx_y[31:16];
  assign fz = sx_z[31:16];
  // corner being read: bit 0 x, bit 1 y, bit 2 z neighbour
  assign cxs = ix + SIDE_W'(rd_cnt_q[0]);
  assign cys = iy + SIDE_W'(rd_cnt_q[1]);
  assign czs = iz + SIDE_W'(rd_cnt_q[2]);

  // band of the current octave
  logic [1:0] band_idx;
  logic       band_on;
  assign band_idx = (k_q < 4'd3) ? 2'd0 : (k_q < 4'd6) ? 2'd1 : 2'd2;
  assign band_on  = bands_q[band_idx];

  // --- next state ---
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.op == OP_POINT) state_d = S_POINT;
          else if (in_data_i.op == OP_FRACTAL) state_d = S_COORD;
        end
      end
      S_POINT: state_d = S_DONE;
      S_COORD: begin
        if (step_q == STEP_COORD_LAST) state_d = S_SEEK;
      end
      S_SEEK: begin
        if (k_q == K_END) state_d = (n_q == 4'd0) ? S_DONE : S_FINAL;
        else if (band_on) state_d = S_READ;
      end
      S_READ: begin
        if (rd_cnt_q == RD_LAST) state_d = S_MATH;
      end
      S_MATH: begin
        if (step_q == STEP_OCT_LAST) state_d = S_SEEK;
      end
      S_FINAL: state_d = S_CLAMP;
      S_CLAMP: begin
        if (diff_q >= {2'b00, den_q, 16'b0}) state_d = S_DONE;
        else state_d = S_DIV;
      end
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --- outputs of the sequencer ---
  always_comb begin
    tbl_req = '0;
    issue   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.op == OP_WRITE) begin
          tbl_req.en    = 1'b1;
          tbl_req.we    = 1'b1;
          tbl_req.addr  = in_data_i.table_index;
          tbl_req.wdata = in_data_i.table_byte;
        end else if (in_acc && in_data_i.op == OP_POINT) begin
          tbl_req.en   = 1'b1;
          tbl_req.addr = cell_addr(in_px[SIDE_W-1:0], in_py[SIDE_W-1:0], in_pz[SIDE_W-1:0]);
        end
      end
      S_READ: begin
        if (rd_cnt_q != RD_LAST) begin
          tbl_req.en   = 1'b1;
          tbl_req.addr = cell_addr(cxs, cys, czs);
        end
      end
      S_COORD, S_MATH: issue = uop_of(step_q);
      default: begin
        tbl_req = '0;
        issue   = '0;
      end
    endcase
  end

  fvn_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // shared multiplier operands
  logic [MA_W-1:0]   mul_a;
  logic [MW_W-1:0]   mul_w;
  logic [PROD_W-1:0] prod;

  always_comb begin
    case (issue.asel)
      A_PX:    mul_a = pt_x_q;
      A_PY:    mul_a = pt_y_q;
      A_PZ:    mul_a = pt_z_q;
      A_BYTE:  mul_a = MA_W'(bt_q[issue.idx]);
      A_R1:    mul_a = MA_W'(r1_q[issue.idx[1:0]]);
      A_R2LO:  mul_a = r2_q[issue.idx[0]][R2_LO_W-1:0];
      A_R2HI:  mul_a = MA_W'(r2_q[issue.idx[0]][R2_W-1:R2_LO_W]);
      default: mul_a = '0;
    endcase
    case (issue.wsel)
      W_CLO:   mul_w = SCALE_LO;
      W_CHI:   mul_w = SCALE_HI;
      W_FX0:   mul_w = ONE_FRAC - MW_W'(fx);
      W_FX1:   mul_w = MW_W'(fx);
      W_FY0:   mul_w = ONE_FRAC - MW_W'(fy);
      W_FY1:   mul_w = MW_W'(fy);
      W_FZ0:   mul_w = ONE_FRAC - MW_W'(fz);
      W_FZ1:   mul_w = MW_W'(fz);
      default: mul_w = '0;
    endcase
  end

  fvn_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .w_i    (mul_w),
    .prod_o (prod)
  );

  // accumulate the product issued last cycle
  logic [ACC_W-1:0] addend, acc_sum, sum_next;
  always_comb begin
    case (uop_q.sh)
      SH_16:   addend = ACC_W'(prod) << 16;
      SH_25:   addend = ACC_W'(prod) << 25;
      default: addend = ACC_W'(prod);
    endcase
    acc_sum  = acc_q + addend;
    sum_next = ACC_W'(sum_q) + addend;
  end

  // final scaling: 13*T against the bias for n octaves
  logic [T_W-1:0]    t_val;
  logic [DIFF_W-1:0] num, bias;
  assign t_val = sum_q[SUM_W-1:SUM_W-T_W];
  assign num   = (DIFF_W'(t_val) << 3) + (DIFF_W'(t_val) << 2) + DIFF_W'(t_val);
  assign bias  = DIFF_W'(BIAS_UNIT * DIFF_W'(n_q));

  // one restoring division step
  logic [DEN_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_q, dsr_q[15]};
  assign q_bit  = (rem_sh >= {1'b0, den_q});

  // --- control registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      shx_q       <= SHIFT_X_RST;
      shy_q       <= SHIFT_Y_RST;
      shz_q       <= SHIFT_Z_RST;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      k_q         <= '0;
      rd_cnt_q    <= '0;
      div_cnt_q   <= '0;
      uop_q       <= '0;
    end else begin
      state_q <= state_d;
      uop_q   <= issue;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SHIFT_X: shx_q <= cfg_data_i;
          REG_SHIFT_Y: shy_q <= cfg_data_i;
          REG_SHIFT_Z: shz_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          step_q <= '0;
          k_q    <= '0;
        end
        S_COORD: step_q <= step_q + 5'd1;
        S_SEEK: begin
          if (k_q != K_END) begin
            if (band_on) begin
              step_q   <= STEP_OCT_FIRST;
              rd_cnt_q <= '0;
            end else begin
              k_q <= k_q + 4'd1;
            end
          end
        end
        S_READ: rd_cnt_q <= rd_cnt_q + 4'd1;
        S_MATH: begin
          step_q <= step_q + 5'd1;
          if (step_q == STEP_OCT_LAST) k_q <= k_q + 4'd1;
        end
        S_CLAMP: div_cnt_q <= '0;
        S_DIV:   div_cnt_q <= div_cnt_q + 4'd1;
        default: ;
      endcase
    end
  end

  // --- datapath registers ---
  always_ff @(posedge clk_i) begin
    if (uop_q.valid) begin
      case (uop_q.dst)
        D_ACC:   acc_q <= addend;
        D_PX:    pp_x_q <= acc_sum[PP_W-1:0];
        D_PY:    pp_y_q <= acc_sum[PP_W-1:0];
        D_PZ:    pp_z_q <= acc_sum[PP_W-1:0];
        D_R1:    r1_q[uop_q.didx] <= acc_sum[R1_W-1:0];
        D_R2:    r2_q[uop_q.didx[0]] <= acc_sum[R2_W-1:0];
        D_SUM:   sum_q <= sum_next[SUM_W-1:0];
        default: ;
      endcase
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pt_x_q  <= in_px;
          pt_y_q  <= in_py;
          pt_z_q  <= in_pz;
          bands_q <= in_data_i.freq_bands;
          n_q     <= 4'(2'(in_data_i.freq_bands[0]) + 2'(in_data_i.freq_bands[1])
                        + 2'(in_data_i.freq_bands[2])) * 4'd3;
          sum_q   <= '0;
        end
      end
      S_POINT: begin
        res_noise_q <= '0;
        res_byte_q  <= tbl_rdata;
      end
      S_SEEK: begin
        res_noise_q <= '0;
        res_byte_q  <= '0;
      end
      S_READ: begin
        if (rd_cnt_q != 4'd0) bt_q[3'(rd_cnt_q - 4'd1)] <= tbl_rdata;
      end
      S_FINAL: begin
        diff_q <= (num > bias) ? (num - bias) : '0;
        den_q  <= DEN_W'(DEN_UNIT * DEN_W'(n_q));
      end
      S_CLAMP: begin
        res_noise_q <= '1;
        rem_q       <= diff_q[16 +: DEN_W];
        dsr_q       <= diff_q[15:0];
        quo_q       <= '0;
      end
      S_DIV: begin
        rem_q <= q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
        dsr_q <= dsr_q << 1;
        quo_q <= {quo_q[14:0], q_bit};
        if (div_cnt_q == DIV_LAST) res_noise_q <= {quo_q[14:0], q_bit};
      end
      S_DONE: begin
        if (out_free) begin
          out_q.noise_value <= res_noise_q;
          out_q.sample_byte <= res_byte_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  // products only come from the scaling and lerp sequences
  a_uop_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uop_q.valid |-> ($past(state_q) == S_COORD || $past(state_q) == S_MATH))
    else $error("product issued outside the microprogram");

  // the partial remainder must stay below the divisor in every division step
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < den_q))
    else $error("division remainder out of range");

  // a new result only appears from the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result word loaded outside done state");

  // averaging is never reached without octaves
  a_final_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |-> (n_q != 4'd0))
    else $error("averaging with zero octaves");
`endif

endmodule

// File: design/fvn_mul.sv
module fvn_mul (
  input  logic                       clk_i,
  input  logic [fvn_pkg::MA_W-1:0]   a_i,
  input  logic [fvn_pkg::MW_W-1:0]   w_i,
  output logic [fvn_pkg::PROD_W-1:0] prod_o
);
  import fvn_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(w_i);
  end

  assign prod_o = prod_q;

endmodule

// File: design/fvn_table.sv
module fvn_table (
  input  logic                       clk_i,
  input  fvn_pkg::tbl_req_t          req_i,
  output logic [fvn_pkg::TBL_DW-1:0] rdata_o
);
  import fvn_pkg::*;

  logic [TBL_DW-1:0] mem [TBL_DEPTH];
  logic [TBL_DW-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/tb_fractal_value_noise_3d_sampler.sv
`timescale 1ns / 100ps

module tb_fractal_value_noise_3d_sampler;
  import fvn_pkg::*;

  localparam int SIDE = 256;
  localparam int SETTLE_CYCLES = 400;       // longer than the slowest fractal word
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;  // spare op code, dropped by the block

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_SHIFT_X;
  logic [SHIFT_W-1:0] cfg_data_i = '0;

  fractal_value_noise_3d_sampler #(.TABLE_SIDE(SIDE)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // shadow of the block's state
  logic [7:0] shadow_table [TBL_DEPTH];
  logic [SHIFT_W-1:0] offs_x = SHIFT_X_RST;
  logic [SHIFT_W-1:0] offs_y = SHIFT_Y_RST;
  logic [SHIFT_W-1:0] offs_z = SHIFT_Z_RST;

  in_word_t pending_words [$];
  out_word_t expected_noise_q [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  // skewed lattice lookup: z shears the x/y cell
  function automatic logic [63:0] cell_byte_at(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] z);
    logic [63:0] cx, cy;
    cx = (x + z * 13) % SIDE;
    cy = (y + z * 17) % SIDE;
    return {56'd0, shadow_table[(cx + cy * SIDE) & 64'hFFFF]};
  endfunction

  // bilinear blend of one z slice, exact in byte * 2^32 units
  function automatic logic [63:0] blend_quad(logic [63:0] ix, logic [63:0] iy,
                                             logic [63:0] iz, logic [63:0] fx,
                                             logic [63:0] fy);
    logic [63:0] nx, ny, top, bot;
    nx = (ix + 1) % SIDE;
    ny = (iy + 1) % SIDE;
    top = cell_byte_at(ix, iy, iz) * (65536 - fx) + cell_byte_at(nx, iy, iz) * fx;
    bot = cell_byte_at(ix, ny, iz) * (65536 - fx) + cell_byte_at(nx, ny, iz) * fx;
    return top * (65536 - fy) + bot * fy;
  endfunction

  function automatic logic [63:0] octave_sum(logic [63:0] px, logic [63:0] py,
                                             logic [63:0] pz, int k);
    logic [63:0] scale, sx, sy, sz, up, lo, iz;
    scale = 64'd8589935 << k;   // 0.002 * 2^k in 0.32
    sx = px * scale;
    sy = py * scale;
    sz = pz * scale;
    iz = (sz >> 32) % SIDE;
    up = blend_quad((sx >> 32) % SIDE, (sy >> 32) % SIDE, iz,
                    (sx >> 16) & 64'hFFFF, (sy >> 16) & 64'hFFFF);
    lo = blend_quad((sx >> 32) % SIDE, (sy >> 32) % SIDE, (iz + 1) % SIDE,
                    (sx >> 16) & 64'hFFFF, (sy >> 16) & 64'hFFFF);
    return up * (65536 - ((sz >> 16) & 64'hFFFF)) + lo * ((sz >> 16) & 64'hFFFF);
  endfunction

  // applies one accepted word to the shadow, queues the result it causes
  task automatic predict_noise(in_word_t w);
    logic [63:0] px, py, pz, total, octaves, t, num, bias, q;
    out_word_t r;
    px = 64'(w.pos_x) + 64'(offs_x);
    py = 64'(w.pos_y) + 64'(offs_y);
    pz = 64'(w.pos_z) + 64'(offs_z);
    r = '0;
    case (w.op)
      OP_WRITE: shadow_table[w.table_index] = w.table_byte;
      OP_POINT: begin
        r.sample_byte = 8'(cell_byte_at(px, py, pz));
        expected_noise_q.push_back(r);
      end
      OP_FRACTAL: begin
        total = 0;
        octaves = 0;
        for (int b = 0; b < 3; b++)
          if (w.freq_bands[b])
            for (int j = 0; j < 3; j++) begin
              total += octave_sum(px, py, pz, b * 3 + j);
              octaves++;
            end
        if (octaves != 0) begin
          // contrast 2.6 about one half, then saturate
          t = total >> 32;
          num = 13 * t;
          bias = 64'd66584576 * octaves;
          q = (num <= bias) ? 0 : (num - bias) / (1270 * octaves);
          r.noise_value = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        expected_noise_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // sender: holds a stalled word, otherwise idles at random or presents the next
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (rst_ni)
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: register writes, accepted words and results
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SHIFT_X: offs_x <= cfg_data_i;
          REG_SHIFT_Y: offs_y <= cfg_data_i;
          REG_SHIFT_Z: offs_z <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        predict_noise(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_noise_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word noise=%h byte=%h",
                     out_data_o.noise_value, out_data_o.sample_byte);
        end else begin
          want = expected_noise_q.pop_front();
          if (out_data_o.noise_value !== want.noise_value ||
              out_data_o.sample_byte !== want.sample_byte) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: noise exp %h got %h, byte exp %h got %h",
                       want.noise_value, out_data_o.noise_value,
                       want.sample_byte, out_data_o.sample_byte);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_word_t build_word(logic [1:0] op, logic [23:0] x,
                                          logic [23:0] y, logic [23:0] z,
                                          logic [2:0] bands);
    in_word_t w;
    w.op = op;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.freq_bands = bands;
    w.table_index = 16'($urandom);
    w.table_byte = 8'($urandom);
    return w;
  endfunction

  function automatic logic [23:0] rand_pos();
    case ($urandom_range(3))
      0: return 24'($urandom_range(4095));
      1: return 24'hFFFFFF - 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic write_shift(logic [1:0] idx, logic [SHIFT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_shifts(logic [SHIFT_W-1:0] x, logic [SHIFT_W-1:0] y,
                            logic [SHIFT_W-1:0] z);
    write_shift(REG_SHIFT_X, x);
    write_shift(REG_SHIFT_Y, y);
    write_shift(REG_SHIFT_Z, z);
  endtask

  // block goes quiet: everything sent, every result back, then a settle gap
  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_noise_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    in_word_t w;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        w = build_word(OP_WRITE, 24'($urandom), 24'($urandom), 24'($urandom),
                       3'($urandom));
      end else if (pick < 55) begin
        w = build_word(OP_POINT, rand_pos(), rand_pos(), rand_pos(), 3'($urandom));
      end else if (pick < 95) begin
        // mostly non-empty band masks, a few empty ones
        w = build_word(OP_FRACTAL, rand_pos(), rand_pos(), rand_pos(),
                       ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(7, 1)));
      end else begin
        w = build_word(OP_UNUSED, 24'($urandom), 24'($urandom), 24'($urandom),
                       3'($urandom));
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    in_word_t w;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every entry so no read ever hits an unwritten byte
    send_idle_pct = 10;
    recv_idle_pct = 58;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      w = build_word(OP_WRITE, 24'($urandom), 24'($urandom), 24'($urandom), 3'($urandom));
      w.table_index = 16'(i);
      w.table_byte = (i == 0) ? 8'h00 : (i == TBL_DEPTH - 1) ? 8'hFF : 8'($urandom);
      pending_words.push_back(w);
    end
    // directed: reset offsets, then zero offsets
    pending_words.push_back(build_word(OP_POINT, 24'd0, 24'd0, 24'd0, 3'd0));
    pending_words.push_back(build_word(OP_FRACTAL, 24'd0, 24'd0, 24'd0, 3'd7));
    drain();
    set_shifts('0, '0, '0);
    pending_words.push_back(build_word(OP_POINT, 24'd0, 24'd0, 24'd0, 3'd7));
    pending_words.push_back(build_word(OP_POINT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 3'd0));
    pending_words.push_back(build_word(OP_POINT, 24'd255, 24'd0, 24'd1, 3'd0));
    for (int b = 0; b < 8; b++)
      pending_words.push_back(build_word(OP_FRACTAL, 24'($urandom), 24'($urandom),
                                         24'($urandom), 3'(b)));
    pending_words.push_back(build_word(OP_FRACTAL, 24'd0, 24'd0, 24'd0, 3'd7));
    pending_words.push_back(build_word(OP_FRACTAL, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 3'd7));
    pending_words.push_back(build_word(OP_FRACTAL, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 3'd4));
    // byte extremes written and then read back at the same cell
    w = build_word(OP_WRITE, 24'd0, 24'd0, 24'd0, 3'd0);
    w.table_index = 16'h0000;
    w.table_byte = 8'hFF;
    pending_words.push_back(w);
    pending_words.push_back(build_word(OP_POINT, 24'd0, 24'd0, 24'd0, 3'd0));
    w.table_index = 16'hFFFF;
    w.table_byte = 8'h00;
    pending_words.push_back(w);
    pending_words.push_back(build_word(OP_POINT, 24'd255, 24'd255, 24'd0, 3'd0));
    pending_words.push_back(build_word(OP_UNUSED, 24'($urandom), 24'($urandom),
                                       24'($urandom), 3'd7));
    pending_words.push_back(build_word(OP_POINT, 24'd100, 24'd200, 24'd3, 3'd0));
    queue_random(330);
    drain();

    // second phase: top offsets, roles of the idle rates swapped
    set_shifts('1, '1, '1);
    send_idle_pct = 58;
    recv_idle_pct = 10;
    queue_random(350);
    drain();

    // last phase: random offsets, full throughput
    set_shifts(14'($urandom), 14'($urandom), 14'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(350);
    drain();

    if (mismatches == 0 && expected_noise_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
design/fvn_pkg.sv
design/fvn_mul.sv
design/fvn_table.sv
design/fractal_value_noise_3d_sampler.sv
test/tb_fractal_value_noise_3d_sampler.sv
